// ----- rtl/core/amwv_pkg.sv -----
// Shared constants and types for the accelerometer magnitude window variance block.
package amwv_pkg;

	localparam int WINDOW  = 64;
	localparam int WIN_LG  = $clog2(WINDOW);
	localparam int AXIS_W  = 16;
	localparam int MAG_W   = 16;
	localparam int SQ_W    = 32;
	localparam int VAR_W   = 30;
	localparam int FILL_W  = WIN_LG + 1;
	localparam int SUM_W   = MAG_W + WIN_LG;
	localparam int SQSUM_W = SQ_W + WIN_LG;
	localparam int NUM_W   = 2 * SUM_W;

	typedef logic [WIN_LG-1:0] slot_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SQ,
		S_RSTART,
		S_ROOT,
		S_OLD,
		S_NEW,
		S_ADD,
		S_VPROD,
		S_OUT
	} state_t;

endpackage

// ----- rtl/core/amwv_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module amwv_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/core/amwv_isqrt.sv -----
// Iterative floor square root, two result bits per cycle.
module amwv_isqrt (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [amwv_pkg::SQ_W-1:0]  radicand,
	output logic                   done,
	output logic [amwv_pkg::MAG_W-1:0] root
);
	import amwv_pkg::*;

	localparam int REM_W  = MAG_W + 2;
	localparam int STEPS  = MAG_W / 2;
	localparam int CNT_W  = $clog2(STEPS);

	logic                busy_q;
	logic                done_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [SQ_W-1:0]     rad_q;
	logic [REM_W-1:0]    rem_q;
	logic [MAG_W-1:0]    root_q;

	logic [SQ_W-1:0]     rad_n;
	logic [REM_W-1:0]    rem_n;
	logic [MAG_W-1:0]    root_n;
	logic [REM_W+1:0]    shifted;
	logic [REM_W+1:0]    trial;

	always_comb begin
		rad_n  = rad_q;
		rem_n  = rem_q;
		root_n = root_q;
		shifted = '0;
		trial   = '0;
		for (int i = 0; i < 2; i++) begin
			shifted = {rem_n, rad_n[SQ_W-1 -: 2]};
			trial   = {2'b00, root_n, 2'b01};
			if (shifted >= trial) begin
				rem_n  = REM_W'(shifted - trial);
				root_n = {root_n[MAG_W-2:0], 1'b1};
			end else begin
				rem_n  = REM_W'(shifted);
				root_n = {root_n[MAG_W-2:0], 1'b0};
			end
			rad_n = {rad_n[SQ_W-3:0], 2'b00};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= rad_n;
			rem_q  <= rem_n;
			root_q <= root_n;
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// ----- rtl/core/accel_magnitude_window_variance_core.sv -----
// Top level: accelerometer magnitude and sliding-window variance of the magnitude.
//
// Input channel: in_valid/in_ready carry one word of accel_x, accel_y, accel_z
// (signed, 1/256 g per LSB). Output channel: out_valid/out_ready carry one word
// of magnitude (floor sqrt of x^2+y^2+z^2), variance_valid and variance
// (floored window variance in LSB^2, zero until the window is full).
// Each input word yields exactly one output word.
// One word is processed at a time, in these steps from accept to output valid:
// squaring of the three axes through one shared 16x16 multiplier, a start of
// the square-root unit and its run (eight iterations at two root bits each,
// then done), then ring read-modify-write and the variance product.
// in_ready is high only in the idle cycle, so a new word is taken only after
// the finished one has been loaded into the output register.
// The magnitude ring is a RAM read at accept; the outgoing entry is subtracted
// only once the ring holds WINDOW magnitudes.
// Reset clears the write slot, fill level and running sums; ring contents are
// not cleared, and an entry read from the ring is only used once the ring is full.
// A finished word sits in the output register while the next input word is
// accepted; if the receiver stalls, processing holds at the last stage.
module accel_magnitude_window_variance_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [amwv_pkg::AXIS_W-1:0] accel_x,
	input  logic signed [amwv_pkg::AXIS_W-1:0] accel_y,
	input  logic signed [amwv_pkg::AXIS_W-1:0] accel_z,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [amwv_pkg::MAG_W-1:0]    magnitude,
	output logic                          variance_valid,
	output logic [amwv_pkg::VAR_W-1:0]    variance
);
	import amwv_pkg::*;

	state_t state_q, state_n;

	logic signed [AXIS_W-1:0] ax_q, ay_q, az_q;
	logic [1:0]               axis_q;
	logic [SQ_W-1:0]          acc_q;
	logic [MAG_W-1:0]         mag_q;
	logic [SQ_W-1:0]          prod_q;
	logic [SUM_W-1:0]         sum_q;
	logic [SQSUM_W-1:0]       sqsum_q;
	logic [NUM_W-1:0]         bprod_q;
	slot_t                    slot_q;
	logic [FILL_W-1:0]        fill_q;
	logic                     out_valid_q;
	logic [MAG_W-1:0]         mag_out_q;
	logic                     vvalid_out_q;
	logic [VAR_W-1:0]         var_out_q;

	logic signed [AXIS_W-1:0] axis_sel;
	logic signed [SQ_W-1:0]   axis_sq;
	logic [MAG_W-1:0]         old_mag;
	logic [MAG_W-1:0]         root;
	logic                     full;
	logic [NUM_W-1:0]         a_term;
	logic [NUM_W-1:0]         num;
	logic                     accept;
	logic                     out_load;
	logic                     ram_we;
	logic                     root_start;
	logic                     root_done;

	assign accept = in_valid && in_ready;
	assign full   = (fill_q == FILL_W'(WINDOW));

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			S_IDLE:   if (in_valid) state_n = S_SQ;
			S_SQ:     if (axis_q == 2'd2) state_n = S_RSTART;
			S_RSTART: state_n = S_ROOT;
			S_ROOT:   if (root_done) state_n = S_OLD;
			S_OLD:    state_n = S_NEW;
			S_NEW:    state_n = S_ADD;
			S_ADD:    state_n = S_VPROD;
			S_VPROD:  state_n = S_OUT;
			S_OUT:    if (!out_valid_q || out_ready) state_n = S_IDLE;
			default:  state_n = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready   = 1'b0;
		root_start = 1'b0;
		ram_we     = 1'b0;
		out_load   = 1'b0;
		unique case (state_q)
			S_IDLE:   in_ready = 1'b1;
			S_RSTART: root_start = 1'b1;
			S_ADD:    ram_we = 1'b1;
			S_OUT:    out_load = !out_valid_q || out_ready;
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			slot_q      <= '0;
			fill_q      <= '0;
			sum_q       <= '0;
			sqsum_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (state_q == S_OLD) begin
				sum_q <= sum_q - (full ? SUM_W'(old_mag) : '0) + SUM_W'(mag_q);
			end
			if (state_q == S_NEW && full) begin
				sqsum_q <= sqsum_q - SQSUM_W'(prod_q);
			end
			if (state_q == S_ADD) begin
				sqsum_q <= sqsum_q + SQSUM_W'(prod_q);
				slot_q  <= slot_q + 1'b1;
				if (!full) begin
					fill_q <= fill_q + 1'b1;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		case (axis_q)
			2'd0:    axis_sel = ax_q;
			2'd1:    axis_sel = ay_q;
			default: axis_sel = az_q;
		endcase
		axis_sq = axis_sel * axis_sel;
	end

	assign a_term = {sqsum_q, WIN_LG'(0)};
	assign num    = (a_term >= bprod_q) ? (a_term - bprod_q) : '0;

	always_ff @(posedge clk) begin
		if (accept) begin
			ax_q   <= accel_x;
			ay_q   <= accel_y;
			az_q   <= accel_z;
			axis_q <= '0;
			acc_q  <= '0;
		end
		if (state_q == S_SQ) begin
			acc_q  <= acc_q + SQ_W'(unsigned'(axis_sq));
			axis_q <= axis_q + 1'b1;
		end
		if (state_q == S_ROOT && root_done) begin
			mag_q <= root;
		end
		if (state_q == S_OLD) begin
			prod_q <= SQ_W'(old_mag) * SQ_W'(old_mag);
		end
		if (state_q == S_NEW) begin
			prod_q <= SQ_W'(mag_q) * SQ_W'(mag_q);
		end
		if (state_q == S_VPROD) begin
			bprod_q <= NUM_W'(sum_q) * NUM_W'(sum_q);
		end
		if (out_load) begin
			mag_out_q    <= mag_q;
			vvalid_out_q <= full;
			var_out_q    <= full ? num[2*WIN_LG +: VAR_W] : '0;
		end
	end

	amwv_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (root_start),
		.radicand (acc_q),
		.done     (root_done),
		.root     (root)
	);

	amwv_ram #(
		.WIDTH (MAG_W),
		.DEPTH (WINDOW)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (slot_q),
		.wdata (mag_q),
		.re    (accept),
		.raddr (slot_q),
		.rdata (old_mag)
	);

	assign out_valid      = out_valid_q;
	assign magnitude      = mag_out_q;
	assign variance_valid = vvalid_out_q;
	assign variance       = var_out_q;

endmodule
